[design/npms_pkg.sv]
// ----------------------------------------------------------------------------
// npms_pkg
// Types and constants shared by the nearest point search block.
// ----------------------------------------------------------------------------
package npms_pkg;

  // Fixed field widths of the transaction ports
  localparam int PORT_COORD_W = 12;
  localparam int STATUS_W     = 2;
  localparam int INDEX_W      = 6;
  localparam int DIST_W       = 13;
  localparam int HELD_W       = 7;

  // Operation selector carried by each input transaction
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

[design/nearest_point_manhattan_search.sv]
// ----------------------------------------------------------------------------
// nearest_point_manhattan_search
// Reference point table with nearest-point (Manhattan distance) queries.
// ----------------------------------------------------------------------------
// Each input transaction loads a reference point, clears the table or queries
// with a point; each gives exactly one result transaction. Load, clear, an
// unused selector and a query on an empty table are answered in the cycle
// after acceptance. A query over N stored points scans the point memory one
// entry per cycle through a single read port and one shared distance/compare
// unit; the input stalls from acceptance until the result, taken from the best
// match after the last entry is compared, is loaded into the output register.
// Ties go to the lowest index. A load into a full table is dropped and
// flagged. The point memory needs no clearing: only entries below the fill
// count are ever used. Input is also held off while a result waits, stalled.
module nearest_point_manhattan_search import npms_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input transaction channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic [PORT_COORD_W-1:0] point_x_i,
  input  logic [PORT_COORD_W-1:0] point_y_i,
  // Result transaction channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [INDEX_W-1:0]      nearest_index_o,
  output logic [DIST_W-1:0]       nearest_distance_o,
  output logic [HELD_W-1:0]       points_held_o
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = COORD_BITS + 1;
  localparam int EXT_W = PORT_COORD_W + 16;

  // Coordinates taken in their low COORD_BITS bits
  logic [EXT_W-1:0]      px_ext, py_ext;
  logic [COORD_BITS-1:0] px, py;
  func_e                 func;

  assign px_ext = {16'd0, point_x_i};
  assign py_ext = {16'd0, point_y_i};
  assign px     = px_ext[COORD_BITS-1:0];
  assign py     = py_ext[COORD_BITS-1:0];
  assign func   = func_e'(func_i);

  // Control and datapath state
  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic [CNT_W-1:0]      scan_addr_q;
  logic                  cmp_vld_q;
  logic                  cmp_last_q;
  logic [AW-1:0]         cmp_idx_q;
  logic [DW-1:0]         best_dist_q;
  logic [AW-1:0]         best_idx_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [INDEX_W-1:0]    index_q;
  logic [DIST_W-1:0]     dist_q;
  logic [HELD_W-1:0]     held_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  is_full;
  logic                  ram_we;
  logic                  issue;
  logic [2*COORD_BITS-1:0] ram_rdata;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_full  = (count_q >= CNT_W'(MAX_POINTS));

  // Sequencer outputs
  always_comb begin
    in_stall_o = !((state_q == ST_IDLE) && out_free);
    ram_we     = in_acc && (func == FUNC_LOAD) && !is_full;
    issue      = (state_q == ST_SCAN) && (scan_addr_q < count_q);
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (func == FUNC_QUERY) && (count_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && cmp_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (in_acc) begin
      if (func == FUNC_CLEAR) begin
        count_d = '0;
      end else if (ram_we) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Point memory: x in the upper half, y in the lower half
  npms_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_POINTS)
  ) u_point_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({px, py}),
    .raddr_i(scan_addr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Shared distance and compare unit
  logic [COORD_BITS-1:0] rx, ry, dx, dy;
  logic [DW-1:0]         cand_dist;
  logic                  better;

  always_comb begin
    rx        = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    ry        = ram_rdata[COORD_BITS-1:0];
    dx        = (qx_q >= rx) ? (qx_q - rx) : (rx - qx_q);
    dy        = (qy_q >= ry) ? (qy_q - ry) : (ry - qy_q);
    cand_dist = DW'(dx) + DW'(dy);
    // strict compare keeps the lowest index on ties
    better    = (cmp_idx_q == '0) || (cand_dist < best_dist_q);
  end

  // Result formation
  logic                      res_load;
  logic [STATUS_W-1:0]       res_status;
  logic [AW-1:0]             res_index;
  logic [DW-1:0]             res_dist;
  logic [CNT_W+HELD_W-1:0]   held_ext;
  logic [AW+INDEX_W-1:0]     index_ext;
  logic [DW+DIST_W-1:0]      dist_ext;

  always_comb begin
    res_load   = 1'b0;
    res_status = STATUS_OK;
    res_index  = '0;
    res_dist   = '0;
    if (in_acc) begin
      unique case (func)
        FUNC_LOAD: begin
          res_load   = 1'b1;
          res_status = is_full ? STATUS_FULL : STATUS_OK;
        end
        FUNC_CLEAR: begin
          res_load = 1'b1;
        end
        FUNC_QUERY: begin
          if (count_q == '0) begin
            res_load   = 1'b1;
            res_status = STATUS_EMPTY;
          end
        end
        default: begin
          res_load = 1'b1;
        end
      endcase
    end else if ((state_q == ST_DONE) && out_free) begin
      res_load  = 1'b1;
      res_index = best_idx_q;
      res_dist  = best_dist_q;
    end
    held_ext  = {{HELD_W{1'b0}}, count_d};
    index_ext = {{INDEX_W{1'b0}}, res_index};
    dist_ext  = {{DIST_W{1'b0}}, res_dist};
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= issue;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (func == FUNC_QUERY)) begin
      qx_q        <= px;
      qy_q        <= py;
      scan_addr_q <= '0;
    end else if (issue) begin
      scan_addr_q <= scan_addr_q + CNT_W'(1);
    end
    cmp_idx_q  <= scan_addr_q[AW-1:0];
    cmp_last_q <= ((scan_addr_q + CNT_W'(1)) == count_q);
    if (cmp_vld_q && better) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= cmp_idx_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      index_q  <= index_ext[INDEX_W-1:0];
      dist_q   <= dist_ext[DIST_W-1:0];
      held_q   <= held_ext[HELD_W-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign nearest_index_o    = index_q;
  assign nearest_distance_o = dist_q;
  assign points_held_o      = held_q;

endmodule

[design/npms_ram.sv]
// ----------------------------------------------------------------------------
// npms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module npms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
